// ----- src/tcop_pkg.sv -----
`default_nettype none

package tcop_pkg;

   // Command codes on the request channel.
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // Fixed field widths of the request and response words.
   localparam int CENTER_BITS = 15;
   localparam int RAD_IN_BITS = 12;
   localparam int POINT_BITS  = 16;

   // Eight symmetric points per step, indexed 0 to 7.
   localparam int         IDX_BITS   = 3;
   localparam logic [2:0] LAST_POINT = 3'd7;

   // Handshake and status of one step passed from the tracer to the emitter.
   typedef struct packed {
      logic valid;
      logic done;
   } step_ctrl_type;

endpackage

`default_nettype wire

// ----- src/tcop_req_if.sv -----
`default_nettype none

interface tcop_req_if import tcop_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic signed [CENTER_BITS-1:0]  center_x;
   logic signed [CENTER_BITS-1:0]  center_y;
   logic        [RAD_IN_BITS-1:0]  outer_radius;
   logic        [RAD_IN_BITS-1:0]  ring_count;

   modport source (output valid, cmd, center_x, center_y, outer_radius, ring_count,
                   input ready);
   modport sink   (input valid, cmd, center_x, center_y, outer_radius, ring_count,
                   output ready);
endinterface

`default_nettype wire

// ----- src/tcop_rsp_if.sv -----
`default_nettype none

interface tcop_rsp_if import tcop_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [POINT_BITS-1:0]  point_x;
   logic signed [POINT_BITS-1:0]  point_y;
   logic                          last_of_step;
   logic                          circle_done;

   modport source (output valid, point_x, point_y, last_of_step, circle_done,
                   input ready);
   modport sink   (input valid, point_x, point_y, last_of_step, circle_done,
                   output ready);
endinterface

`default_nettype wire

// ----- src/thick_circle_outline_points.sv -----
// Thick circle outline point generator.
// The request channel carries command words. A start word (cmd low) loads the
// center, the outer radius and the ring count; it produces no response. An
// advance word (cmd high) produces the eight symmetric points of the current
// step of the current ring, in a fixed order, and then moves the tracer on by
// one decision step, dropping to the next smaller ring when a ring is finished.
// An advance word while no circle is running produces nothing.
// The response channel carries one point per word. The eighth word of a step
// has last_of_step set, and the eighth word of the final step of the circle
// also has circle_done set.
// The first point of a step passes through the input register, the step bank
// and the output register after its advance word is accepted.
// Throughput: one point per cycle while the receiver does not stall; the step
// bank is reloaded in the same cycle that its eighth point enters the output
// register. Start words and idle advances leave the input register without
// waiting for the step bank. When the receiver stalls, the output register
// holds its word, the bank holds its step and the input register fills,
// after which ready drops. Reset empties every stage and returns the tracer
// to idle.
`default_nettype none

module thick_circle_outline_points import tcop_pkg::*; #(
   parameter int RADIUS_BITS = 12,
   parameter int COORD_BITS  = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tcop_req_if.sink   req_chan,
   tcop_rsp_if.source rsp_chan
);

   // Input register: parts the request handshake from the tracer.
   logic                          in_valid_ff, in_valid_in;
   logic                          in_cmd_ff;
   logic signed [CENTER_BITS-1:0] in_cx_ff, in_cy_ff;
   logic [RAD_IN_BITS-1:0]        in_rad_ff, in_rings_ff;

   logic                          item_ready;
   logic                          req_take;
   step_ctrl_type                 step_ctrl;
   logic                          step_ready;
   logic signed [CENTER_BITS-1:0] step_cen_x, step_cen_y;
   logic signed [RADIUS_BITS:0]   step_off_x, step_off_y;

   // The register takes a new word whenever it is empty or its word leaves now.
   assign req_chan.ready = !in_valid_ff || item_ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_chan.cmd;
         in_cx_ff    <= req_chan.center_x;
         in_cy_ff    <= req_chan.center_y;
         in_rad_ff   <= req_chan.outer_radius;
         in_rings_ff <= req_chan.ring_count;
      end
   end

   // Tracer: circle state and the decision update.
   tcop_step #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (in_valid_ff),
      .item_ready   (item_ready),
      .cmd          (in_cmd_ff),
      .center_x     (in_cx_ff),
      .center_y     (in_cy_ff),
      .outer_radius (in_rad_ff),
      .ring_count   (in_rings_ff),
      .step_ctrl    (step_ctrl),
      .step_ready   (step_ready),
      .step_cen_x   (step_cen_x),
      .step_cen_y   (step_cen_y),
      .step_off_x   (step_off_x),
      .step_off_y   (step_off_y)
   );

   // Emitter: step bank, point mirroring and the output register.
   tcop_emit #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .step_ctrl  (step_ctrl),
      .step_ready (step_ready),
      .step_cen_x (step_cen_x),
      .step_cen_y (step_cen_y),
      .step_off_x (step_off_x),
      .step_off_y (step_off_y),
      .rsp_chan   (rsp_chan)
   );

   // The end of the circle is only ever flagged on the closing word of a step.
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.circle_done |-> rsp_chan.last_of_step)
      else $error("circle_done without last_of_step");

   // The word after a step's closing word opens a new step.
   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_of_step
      |=> !(rsp_chan.valid && rsp_chan.last_of_step))
      else $error("two closing words in a row");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire

// ----- src/tcop_step.sv -----
`default_nettype none

// Circle state and one decision step per advance word.
module tcop_step import tcop_pkg::*; #(
   parameter int RADIUS_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   output      logic                           item_ready,
   input  wire logic                           cmd,
   input  wire logic signed [CENTER_BITS-1:0]  center_x,
   input  wire logic signed [CENTER_BITS-1:0]  center_y,
   input  wire logic        [RAD_IN_BITS-1:0]  outer_radius,
   input  wire logic        [RAD_IN_BITS-1:0]  ring_count,
   output      step_ctrl_type                  step_ctrl,
   input  wire logic                           step_ready,
   output      logic signed [CENTER_BITS-1:0]  step_cen_x,
   output      logic signed [CENTER_BITS-1:0]  step_cen_y,
   output      logic signed [RADIUS_BITS:0]    step_off_x,
   output      logic signed [RADIUS_BITS:0]    step_off_y
);

   localparam int OW  = RADIUS_BITS + 1;
   localparam int DW  = RADIUS_BITS + 2;
   localparam int TW  = RADIUS_BITS + 3;
   localparam int RIN = (RADIUS_BITS < RAD_IN_BITS) ? RADIUS_BITS : RAD_IN_BITS;

   logic                          busy_ff, busy_in;
   logic signed [CENTER_BITS-1:0] cen_x_ff, cen_x_in;
   logic signed [CENTER_BITS-1:0] cen_y_ff, cen_y_in;
   logic [RADIUS_BITS-1:0]        outer_rad_ff, outer_rad_in;
   logic [RADIUS_BITS-1:0]        rings_total_ff, rings_total_in;
   logic [RADIUS_BITS-1:0]        ring_index_ff, ring_index_in;
   logic signed [OW-1:0]          off_x_ff, off_x_in;
   logic signed [OW-1:0]          off_y_ff, off_y_in;
   logic signed [DW-1:0]          dec_ff, dec_in;

   logic                          is_adv;
   logic                          take;
   logic [RADIUS_BITS-1:0]        load_rad;
   logic [RADIUS_BITS-1:0]        load_rings;
   logic signed [TW-1:0]          d_t, ox_t, oy_t, r_t, d_nx, r_next;
   logic signed [OW-1:0]          ox_nx, oy_nx;
   logic [RADIUS_BITS-1:0]        ri_next;
   logic                          ring_end;
   logic                          circle_end;

   assign is_adv     = (cmd == CMD_ADVANCE);
   assign item_ready = !(is_adv && busy_ff) || step_ready;
   assign take       = item_valid && item_ready;

   assign load_rad   = RADIUS_BITS'(outer_radius[RIN-1:0]);
   assign load_rings = RADIUS_BITS'(ring_count[RIN-1:0]);

   // Decision update for the current step.
   always_comb begin
      d_t  = TW'(dec_ff);
      ox_t = TW'(off_x_ff);
      oy_t = TW'(off_y_ff);
      r_t  = $signed(TW'(outer_rad_ff)) - $signed(TW'(ring_index_ff));
      if (d_t >= (ox_t <<< 1)) begin
         d_nx  = d_t - (ox_t <<< 1) - TW'(1);
         ox_nx = off_x_ff + OW'(1);
         oy_nx = off_y_ff;
      end else if (d_t < ((r_t - oy_t) <<< 1)) begin
         d_nx  = d_t + (oy_t <<< 1) - TW'(1);
         ox_nx = off_x_ff;
         oy_nx = off_y_ff - OW'(1);
      end else begin
         d_nx  = d_t + ((oy_t - ox_t - TW'(1)) <<< 1);
         ox_nx = off_x_ff + OW'(1);
         oy_nx = off_y_ff - OW'(1);
      end
      ring_end   = (oy_nx < ox_nx);
      ri_next    = ring_index_ff + RADIUS_BITS'(1);
      circle_end = (ri_next >= rings_total_ff) || (ri_next > outer_rad_ff);
      r_next     = $signed(TW'(outer_rad_ff)) - $signed(TW'(ri_next));
   end

   always_comb begin
      busy_in        = busy_ff;
      cen_x_in       = cen_x_ff;
      cen_y_in       = cen_y_ff;
      outer_rad_in   = outer_rad_ff;
      rings_total_in = rings_total_ff;
      ring_index_in  = ring_index_ff;
      off_x_in       = off_x_ff;
      off_y_in       = off_y_ff;
      dec_in         = dec_ff;
      if (take) begin
         if (!is_adv) begin
            cen_x_in       = center_x;
            cen_y_in       = center_y;
            outer_rad_in   = load_rad;
            rings_total_in = load_rings;
            ring_index_in  = '0;
            busy_in        = (load_rings != '0);
            off_x_in       = '0;
            if (load_rings != '0) begin
               off_y_in = $signed(OW'(load_rad));
               dec_in   = $signed(DW'(load_rad)) - DW'(1);
            end else begin
               off_y_in = '0;
               dec_in   = '0;
            end
         end else if (busy_ff) begin
            off_x_in = ox_nx;
            off_y_in = oy_nx;
            dec_in   = DW'(d_nx);
            if (ring_end) begin
               if (circle_end) begin
                  busy_in       = 1'b0;
                  ring_index_in = '0;
                  off_x_in      = '0;
                  off_y_in      = '0;
                  dec_in        = '0;
               end else begin
                  ring_index_in = ri_next;
                  off_x_in      = '0;
                  off_y_in      = OW'(r_next);
                  dec_in        = DW'(r_next - TW'(1));
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         cen_x_ff       <= '0;
         cen_y_ff       <= '0;
         outer_rad_ff   <= '0;
         rings_total_ff <= '0;
         ring_index_ff  <= '0;
         off_x_ff       <= '0;
         off_y_ff       <= '0;
         dec_ff         <= '0;
      end else begin
         busy_ff        <= busy_in;
         cen_x_ff       <= cen_x_in;
         cen_y_ff       <= cen_y_in;
         outer_rad_ff   <= outer_rad_in;
         rings_total_ff <= rings_total_in;
         ring_index_ff  <= ring_index_in;
         off_x_ff       <= off_x_in;
         off_y_ff       <= off_y_in;
         dec_ff         <= dec_in;
      end
   end

   assign step_ctrl.valid = item_valid && is_adv && busy_ff;
   assign step_ctrl.done  = ring_end && circle_end;
   assign step_cen_x      = cen_x_ff;
   assign step_cen_y      = cen_y_ff;
   assign step_off_x      = off_x_ff;
   assign step_off_y      = off_y_ff;

endmodule

`default_nettype wire

// ----- src/tcop_emit.sv -----
`default_nettype none

// Holds one step and sends its eight symmetric points through the output register.
module tcop_emit import tcop_pkg::*; #(
   parameter int RADIUS_BITS = 12,
   parameter int COORD_BITS  = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire step_ctrl_type                  step_ctrl,
   output      logic                           step_ready,
   input  wire logic signed [CENTER_BITS-1:0]  step_cen_x,
   input  wire logic signed [CENTER_BITS-1:0]  step_cen_y,
   input  wire logic signed [RADIUS_BITS:0]    step_off_x,
   input  wire logic signed [RADIUS_BITS:0]    step_off_y,
   tcop_rsp_if.source                          rsp_chan
);

   localparam int OW    = RADIUS_BITS + 1;
   localparam int SW    = ((CENTER_BITS > OW) ? CENTER_BITS : OW) + 1;
   localparam int SHIFT = 32 - COORD_BITS;

   logic                          bank_valid_ff, bank_valid_in;
   logic [IDX_BITS-1:0]           idx_ff, idx_in;
   logic                          bank_done_ff;
   logic signed [CENTER_BITS-1:0] bank_cx_ff, bank_cy_ff;
   logic signed [OW-1:0]          bank_ox_ff, bank_oy_ff;

   logic                          out_valid_ff, out_valid_in;
   logic signed [POINT_BITS-1:0]  out_x_ff, out_y_ff;
   logic                          out_last_ff, out_done_ff;

   logic                          out_free;
   logic                          move;
   logic                          load;
   logic signed [OW-1:0]          x_off, y_off;
   logic signed [SW-1:0]          x_sum, y_sum;
   logic signed [31:0]            x_wide, y_wide, x_wrap, y_wrap;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign move       = bank_valid_ff && out_free;
   assign step_ready = !bank_valid_ff || ((idx_ff == LAST_POINT) && out_free);
   assign load       = step_ctrl.valid && step_ready;

   // Bit 0 of the index swaps the offsets, bit 1 negates x and bit 2 negates y.
   always_comb begin
      x_off  = idx_ff[0] ? bank_oy_ff : bank_ox_ff;
      y_off  = idx_ff[0] ? bank_ox_ff : bank_oy_ff;
      x_sum  = idx_ff[1] ? SW'(bank_cx_ff) - SW'(x_off) : SW'(bank_cx_ff) + SW'(x_off);
      y_sum  = idx_ff[2] ? SW'(bank_cy_ff) - SW'(y_off) : SW'(bank_cy_ff) + SW'(y_off);
      x_wide = 32'(x_sum);
      y_wide = 32'(y_sum);
      x_wrap = (x_wide <<< SHIFT) >>> SHIFT;
      y_wrap = (y_wide <<< SHIFT) >>> SHIFT;
   end

   always_comb begin
      bank_valid_in = bank_valid_ff;
      idx_in        = idx_ff;
      if (move) begin
         idx_in = idx_ff + IDX_BITS'(1);
         if (idx_ff == LAST_POINT) begin
            bank_valid_in = 1'b0;
         end
      end
      if (load) begin
         bank_valid_in = 1'b1;
         idx_in        = '0;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = bank_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff <= 1'b0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         bank_valid_ff <= bank_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bank_done_ff <= step_ctrl.done;
         bank_cx_ff   <= step_cen_x;
         bank_cy_ff   <= step_cen_y;
         bank_ox_ff   <= step_off_x;
         bank_oy_ff   <= step_off_y;
      end
      if (move) begin
         out_x_ff    <= x_wrap[POINT_BITS-1:0];
         out_y_ff    <= y_wrap[POINT_BITS-1:0];
         out_last_ff <= (idx_ff == LAST_POINT);
         out_done_ff <= (idx_ff == LAST_POINT) && bank_done_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.point_x      = out_x_ff;
   assign rsp_chan.point_y      = out_y_ff;
   assign rsp_chan.last_of_step = out_last_ff;
   assign rsp_chan.circle_done  = out_done_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import tcop_pkg::*;

   // The block is built with its default sizes; the predictor uses the same ones.
   localparam int RADIUS_BITS  = 12;
   localparam int COORD_BITS   = 16;
   localparam int RADIUS_MASK  = (1 << RADIUS_BITS) - 1;

   // Roughly how many advance words the random part of the run queues.
   localparam int RANDOM_ITEMS = 70;
   // Cycles without a single word moving on either channel before the run is
   // declared hung. The longest honest silence is a sender gap plus the trip
   // through the input, bank and output registers plus a receiver stall.
   localparam int QUIET_LIMIT  = 500;
   // Cycles to keep watching the response channel after the last expected
   // point, so that stray extra points are still caught.
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_LIMIT = 10;

   // One command word as it travels on the request channel.
   typedef struct {
      logic                          cmd;
      logic signed [CENTER_BITS-1:0] cx;
      logic signed [CENTER_BITS-1:0] cy;
      logic [RAD_IN_BITS-1:0]        radius;
      logic [RAD_IN_BITS-1:0]        rings;
   } circle_word_type;

   // One emitted pixel as it travels on the response channel.
   typedef struct packed {
      logic signed [POINT_BITS-1:0] x;
      logic signed [POINT_BITS-1:0] y;
      logic                         last;
      logic                         done;
   } pixel_type;

   logic clock;
   logic reset;

   tcop_req_if req_if ();
   tcop_rsp_if rsp_if ();

   thick_circle_outline_points u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #6 clock = ~clock;

   // Command words waiting to be sent, and pixels the block still owes us.
   circle_word_type cmd_backlog[$];
   pixel_type       points_due[$];

   // The tracer's own copy of the circle state. Everything is kept as plain
   // integers so that the decision arithmetic never wraps.
   bit tracing;
   int ctr_x, ctr_y;
   int rad_outer, rings_wanted, ring_no;
   int ofs_x, ofs_y, dec;

   // Handshake bookkeeping shared between the clocked blocks.
   bit        word_taken;
   bit        point_taken;
   int        words_taken;
   int        calm_mark;
   int        quiet_cycles;
   int        mismatches;
   int        send_gap;
   int        hold_left;
   int        advances_queued;
   pixel_type seen;
   pixel_type due;

   // Wrap a coordinate to COORD_BITS two's complement, then sign extend it
   // into the response field.
   function automatic logic signed [POINT_BITS-1:0] wrap_coord(int v);
      int s;
      s = (v <<< (32 - COORD_BITS)) >>> (32 - COORD_BITS);
      return s[POINT_BITS-1:0];
   endfunction

   // A fresh ring starts at the top of the circle with the decision at r-1.
   function automatic void start_ring();
      ofs_x = 0;
      ofs_y = rad_outer - ring_no;
      dec   = rad_outer - ring_no - 1;
   endfunction

   // Apply one accepted command word to the tracer and queue the pixels that
   // it must produce. An advance emits the eight mirror images of the current
   // offset pair and then takes one decision step.
   function automatic void trace_word(circle_word_type w);
      int        px[8];
      int        py[8];
      int        ring_r;
      bit        finished;
      pixel_type p;
      if (w.cmd == CMD_START) begin
         ctr_x        = int'(w.cx);
         ctr_y        = int'(w.cy);
         rad_outer    = int'(w.radius) & RADIUS_MASK;
         rings_wanted = int'(w.rings) & RADIUS_MASK;
         ring_no      = 0;
         tracing      = (rings_wanted != 0);
         if (tracing) begin
            start_ring();
         end else begin
            ofs_x = 0;
            ofs_y = 0;
            dec   = 0;
         end
         return;
      end
      // An advance with no circle running is simply swallowed.
      if (!tracing) return;

      px = '{ctr_x + ofs_x, ctr_x + ofs_y, ctr_x - ofs_x, ctr_x - ofs_y,
             ctr_x + ofs_x, ctr_x + ofs_y, ctr_x - ofs_x, ctr_x - ofs_y};
      py = '{ctr_y + ofs_y, ctr_y + ofs_x, ctr_y + ofs_y, ctr_y + ofs_x,
             ctr_y - ofs_y, ctr_y - ofs_x, ctr_y - ofs_y, ctr_y - ofs_x};

      // The middle test uses the radius of the ring being traced.
      ring_r   = rad_outer - ring_no;
      finished = 1'b0;
      if (dec >= 2 * ofs_x) begin
         dec   = dec - (2 * ofs_x + 1);
         ofs_x = ofs_x + 1;
      end else if (dec < 2 * (ring_r - ofs_y)) begin
         dec   = dec + 2 * ofs_y - 1;
         ofs_y = ofs_y - 1;
      end else begin
         dec   = dec + 2 * (ofs_y - ofs_x - 1);
         ofs_y = ofs_y - 1;
         ofs_x = ofs_x + 1;
      end

      // When the offsets cross, the ring is complete. The circle ends when the
      // ring count is used up or the next ring would have a negative radius.
      if (ofs_y < ofs_x) begin
         ring_no = ring_no + 1;
         if (ring_no >= rings_wanted || ring_no > rad_outer) begin
            finished = 1'b1;
            tracing  = 1'b0;
            ring_no  = 0;
            ofs_x    = 0;
            ofs_y    = 0;
            dec      = 0;
         end else begin
            start_ring();
         end
      end

      for (int k = 0; k < 8; k++) begin
         p.x    = wrap_coord(px[k]);
         p.y    = wrap_coord(py[k]);
         p.last = (k == 7);
         p.done = (k == 7) && finished;
         points_due.push_back(p);
      end
   endfunction

   // Upper bound on the advances a circle needs: every step shrinks the gap
   // between off_y and off_x by at least one, so a ring of radius r ends
   // within r+1 steps. Rings below radius zero are never traced.
   function automatic int step_bound(int rad, int rings);
      int total;
      total = 0;
      for (int i = 0; i < rings && i <= rad; i++) total += rad - i + 1;
      return total;
   endfunction

   task automatic queue_start(int cx, int cy, int rad, int rings);
      circle_word_type w;
      w.cmd    = CMD_START;
      w.cx     = CENTER_BITS'(cx);
      w.cy     = CENTER_BITS'(cy);
      w.radius = RAD_IN_BITS'(rad);
      w.rings  = RAD_IN_BITS'(rings);
      cmd_backlog.push_back(w);
   endtask

   // Advance words carry random junk in the fields that only a start uses.
   task automatic queue_advances(int n);
      circle_word_type w;
      repeat (n) begin
         w.cmd    = CMD_ADVANCE;
         w.cx     = CENTER_BITS'($urandom_range(0, 32767));
         w.cy     = CENTER_BITS'($urandom_range(0, 32767));
         w.radius = RAD_IN_BITS'($urandom_range(0, 4095));
         w.rings  = RAD_IN_BITS'($urandom_range(0, 4095));
         cmd_backlog.push_back(w);
      end
      advances_queued += n;
   endtask

   // Sampling side. Both channels are looked at on the rising edge only; the
   // request word that was just taken drives the tracer, and every response
   // word is checked against the oldest pixel still owed.
   always @(posedge clock) begin
      word_taken  = !reset && req_if.valid && req_if.ready;
      point_taken = !reset && rsp_if.valid && rsp_if.ready;

      if (point_taken) begin
         seen = '{rsp_if.point_x, rsp_if.point_y, rsp_if.last_of_step, rsp_if.circle_done};
         if (points_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected point x=%0d y=%0d last=%b done=%b",
                        $realtime, seen.x, seen.y, seen.last, seen.done);
         end else begin
            due = points_due.pop_front();
            if (seen !== due) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: point mismatch: expected x=%0d y=%0d last=%b done=%b, %s",
                           $realtime, due.x, due.y, due.last, due.done,
                           $sformatf("got x=%0d y=%0d last=%b done=%b",
                                     seen.x, seen.y, seen.last, seen.done));
            end
         end
      end

      if (word_taken) begin
         trace_word(cmd_backlog.pop_front());
         words_taken++;
      end

      quiet_cycles = (word_taken || point_taken) ? 0 : quiet_cycles + 1;
   end

   // Request driver. A word that is on the bus stays there until it is
   // taken; only after that may a gap burst begin. Over the last quarter of
   // the words there are no gaps at all.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !word_taken) begin
         req_if.valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_if.valid <= 1'b0;
         send_gap--;
      end else if (cmd_backlog.size() == 0) begin
         req_if.valid <= 1'b0;
      end else if (words_taken < calm_mark && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         send_gap = $urandom_range(0, 6);
      end else begin
         req_if.valid        <= 1'b1;
         req_if.cmd          <= cmd_backlog[0].cmd;
         req_if.center_x     <= cmd_backlog[0].cx;
         req_if.center_y     <= cmd_backlog[0].cy;
         req_if.outer_radius <= cmd_backlog[0].radius;
         req_if.ring_count   <= cmd_backlog[0].rings;
      end
   end

   // Response back-pressure, in random bursts, also switched off over the last
   // quarter of the run.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (words_taken < calm_mark && $urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         hold_left = $urandom_range(0, 6);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      int cx, cy, rad, rings, steps, pick;

      clock               = 1'b0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.cmd          = CMD_START;
      req_if.center_x     = '0;
      req_if.center_y     = '0;
      req_if.outer_radius = '0;
      req_if.ring_count   = '0;
      rsp_if.ready        = 1'b0;
      tracing             = 1'b0;
      ctr_x               = 0;
      ctr_y               = 0;
      rad_outer           = 0;
      rings_wanted        = 0;
      ring_no             = 0;
      ofs_x               = 0;
      ofs_y               = 0;
      dec                 = 0;
      words_taken         = 0;
      quiet_cycles        = 0;
      mismatches          = 0;
      send_gap            = 0;
      hold_left           = 0;
      advances_queued     = 0;

      // Directed opening. An advance straight out of reset must be ignored.
      queue_advances(1);
      // A single ring of radius zero puts all eight points on the center; the
      // second advance lands on an idle block.
      queue_start(0, 0, 0, 1);
      queue_advances(2);
      // A start with no rings leaves the block idle.
      queue_start(100, -100, 5, 0);
      queue_advances(1);
      // Five rings asked for on radius two: the rings below radius zero are
      // dropped and the circle ends early. The center sits at the extremes.
      queue_start(16383, -16384, 2, 5);
      queue_advances(step_bound(2, 5) + 1);
      // The largest circle at the opposite corner, abandoned after a few
      // steps by a new start while it is still running.
      queue_start(-16384, 16383, 4095, 4095);
      queue_advances(3);
      queue_start(-1, 1, 1, 1);
      queue_advances(step_bound(1, 1));

      // Random part. Most of it is complete small circles with random
      // centers; some circles are cut short, some have ring counts far above
      // their radius, and a few are huge ones abandoned after one to four steps.
      advances_queued = 0;
      while (advances_queued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         cx   = int'($urandom_range(0, 32767)) - 16384;
         cy   = int'($urandom_range(0, 32767)) - 16384;
         if (pick == 0) begin
            queue_start(cx, cy, $urandom_range(0, 4095), $urandom_range(1, 4095));
            queue_advances($urandom_range(1, 4));
         end else if (pick == 1) begin
            // A stray word of either kind.
            if ($urandom_range(0, 1))
               queue_advances(1);
            else
               queue_start(cx, cy, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end else begin
            rad   = $urandom_range(0, 8);
            rings = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, 4);
            steps = step_bound(rad, rings);
            if ($urandom_range(0, 4) == 0)
               steps = $urandom_range(0, steps);
            else
               steps += $urandom_range(0, 1);
            queue_start(cx, cy, rad, rings);
            queue_advances(steps);
         end
      end
      calm_mark = cmd_backlog.size() * 3 / 4;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every word to be sent and every owed point to arrive, then
      // keep watching a little longer for anything extra.
      while ((cmd_backlog.size() != 0 || points_due.size() != 0)
             && quiet_cycles < QUIET_LIMIT)
         @(negedge clock);
      if (quiet_cycles < QUIET_LIMIT) repeat (DRAIN_CYCLES) @(negedge clock);

      if (quiet_cycles >= QUIET_LIMIT)
         $display("%0t: watchdog expired, %0d words unsent, %0d points owed",
                  $realtime, cmd_backlog.size(), points_due.size());
      else if (points_due.size() != 0)
         $display("%0t: %0d points never arrived", $realtime, points_due.size());

      if (quiet_cycles < QUIET_LIMIT && mismatches == 0 && points_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
